// ===== rtl/bascos_pkg.sv =====
// Package for the binary-angle sine/cosine core: fixed-point types, Q30
// polynomial coefficients, quadrant codes and the Q30-to-Q15 rounding step.
// No dependencies.
`default_nettype none

package bascos_pkg;

    typedef logic signed [15:0] t_q15;
    typedef logic signed [31:0] t_q30;
    typedef logic signed [61:0] t_prod;
    typedef logic        [30:0] t_sq;

    // Register stages from input beat to output register.
    localparam int unsigned Stages = 11;

    // Sine coefficients, Q30, for t, t^3, t^5 and t^7.
    localparam t_q30 SinC1 = 32'sd843314816;
    localparam t_q30 SinC3 = -32'sd86699680;
    localparam t_q30 SinC5 = 32'sd2673479;
    localparam t_q30 SinC7 = -32'sd38523;

    // Cosine coefficients, Q30, for t^0, t^2, t^4, t^6 and t^8.
    localparam t_q30 CosC0 = 32'sd1073741824;
    localparam t_q30 CosC2 = -32'sd331168975;
    localparam t_q30 CosC4 = 32'sd17023471;
    localparam t_q30 CosC6 = -32'sd349974;
    localparam t_q30 CosC8 = 32'sd3790;

    localparam logic [15:0] OctantBias = 16'h2000;
    localparam t_q15        SatLimit   = 16'sd32767;

    // Quadrant codes after the octant bias.
    localparam logic [1:0] QuadFirst  = 2'd0;
    localparam logic [1:0] QuadSecond = 2'd1;
    localparam logic [1:0] QuadThird  = 2'd2;
    localparam logic [1:0] QuadFourth = 2'd3;

    // Round a Q30 value to Q15 (add half, floor) and clamp to +/-32767.
    function automatic t_q15 round_sat(input t_q30 q30);
        logic signed [32:0] v;
        logic signed [17:0] r;
        v = 33'(q30) + 33'sd16384;
        r = 18'(v >>> 15);
        if (r > 18'sd32767) begin
            return SatLimit;
        end
        if (r < -18'sd32767) begin
            return -SatLimit;
        end
        return r[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/binary_angle_sine_cosine_core.sv =====
// Top level of the binary-angle sine/cosine core: eleven-stage pipeline of
// Horner steps. Depends on bascos_pkg.
//
// Takes a 16-bit binary angle (65536 units per turn) and returns sine and
// cosine together as signed Q1.15, clamped to +/-32767. One beat enters per
// cycle while the output is not stalled, and each beat passes through the stages
// in order to the output register. The eleven stages are
// the residue stage, the square stage, the four Horner steps, each split into a
// multiply stage and a shift-add stage, and the output register.
// A stall on the output freezes the whole pipeline, so o_stall follows i_stall
// whenever a result waits in the output register.
`default_nettype none

module binary_angle_sine_cosine_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire  [15:0]         i_angle,
    output logic                o_valid,
    input  wire                 i_stall,
    output bascos_pkg::t_q15    o_sine_value,
    output bascos_pkg::t_q15    o_cosine_value
);
    import bascos_pkg::*;

    function automatic t_prod mul_sq(input t_sq sq, input t_q30 v);
        t_prod a;
        a = t_prod'($signed({1'b0, sq}));
        return a * t_prod'(v);
    endfunction

    function automatic t_q30 shift_add(input t_prod p, input t_q30 coef);
        t_prod tmp;
        tmp = (p >>> 30) + t_prod'(coef);
        return tmp[31:0];
    endfunction

    logic                r_vld [Stages];
    logic                en;

    // stage 1: residue and quadrant
    t_q15       r_x1;
    logic [1:0] r_quad1;
    // stage 2: square
    t_sq        r_sq2;
    t_q15       r_x2;
    logic [1:0] r_quad2;
    // stages 3..8: Horner steps
    t_prod      r_ps3, r_pc3;
    t_q30       r_s4, r_c4;
    t_prod      r_ps5, r_pc5;
    t_q30       r_s6, r_c6;
    t_prod      r_ps7, r_pc7;
    t_q30       r_s8, r_c8;
    t_sq        r_sq3, r_sq4, r_sq5, r_sq6, r_sq7, r_sq8;
    t_q15       r_x3, r_x4, r_x5, r_x6, r_x7, r_x8;
    logic [1:0] r_quad3, r_quad4, r_quad5, r_quad6, r_quad7, r_quad8;
    // stage 9: last products, stage 10: final Q30 values
    t_prod      r_ps9, r_pc9;
    t_q30       r_s10, r_c10;
    logic [1:0] r_quad9, r_quad10;
    // stage 11: output register
    t_q15       r_sin11, r_cos11;

    logic [15:0] n_biased;
    t_q15        n_x1;
    t_prod       n_sq_full, n_sin_q45;
    t_q30        n_s10;
    t_q15        n_sv, n_cv, n_sin11, n_cos11;

    assign en      = !(r_vld[Stages-1] && i_stall);
    assign o_stall = r_vld[Stages-1] && i_stall;
    assign o_valid = r_vld[Stages-1];
    assign o_sine_value   = r_sin11;
    assign o_cosine_value = r_cos11;

    always_comb begin
        n_biased  = i_angle + OctantBias;
        n_x1      = {i_angle[13:0], 2'b00};
        n_sq_full = t_prod'(r_x1) * t_prod'(r_x1);
        n_sin_q45 = r_ps9 >>> 15;
        n_s10     = n_sin_q45[31:0];
        n_sv      = round_sat(r_s10);
        n_cv      = round_sat(r_c10);
        case (r_quad10)
            QuadFirst: begin
                n_sin11 = n_sv;
                n_cos11 = n_cv;
            end
            QuadSecond: begin
                n_sin11 = n_cv;
                n_cos11 = -n_sv;
            end
            QuadThird: begin
                n_sin11 = -n_sv;
                n_cos11 = -n_cv;
            end
            QuadFourth: begin
                n_sin11 = -n_cv;
                n_cos11 = n_sv;
            end
            default: begin
                n_sin11 = n_sv;
                n_cos11 = n_cv;
            end
        endcase
    end

    // valid bits travel with the beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < Stages; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < Stages; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x1    <= n_x1;
            r_quad1 <= n_biased[15:14];

            r_sq2   <= n_sq_full[30:0];
            r_x2    <= r_x1;
            r_quad2 <= r_quad1;

            r_ps3   <= mul_sq(r_sq2, SinC7);
            r_pc3   <= mul_sq(r_sq2, CosC8);
            r_sq3   <= r_sq2;
            r_x3    <= r_x2;
            r_quad3 <= r_quad2;

            r_s4    <= shift_add(r_ps3, SinC5);
            r_c4    <= shift_add(r_pc3, CosC6);
            r_sq4   <= r_sq3;
            r_x4    <= r_x3;
            r_quad4 <= r_quad3;

            r_ps5   <= mul_sq(r_sq4, r_s4);
            r_pc5   <= mul_sq(r_sq4, r_c4);
            r_sq5   <= r_sq4;
            r_x5    <= r_x4;
            r_quad5 <= r_quad4;

            r_s6    <= shift_add(r_ps5, SinC3);
            r_c6    <= shift_add(r_pc5, CosC4);
            r_sq6   <= r_sq5;
            r_x6    <= r_x5;
            r_quad6 <= r_quad5;

            r_ps7   <= mul_sq(r_sq6, r_s6);
            r_pc7   <= mul_sq(r_sq6, r_c6);
            r_sq7   <= r_sq6;
            r_x7    <= r_x6;
            r_quad7 <= r_quad6;

            r_s8    <= shift_add(r_ps7, SinC1);
            r_c8    <= shift_add(r_pc7, CosC2);
            r_sq8   <= r_sq7;
            r_x8    <= r_x7;
            r_quad8 <= r_quad7;

            // sine takes its odd factor here, cosine its last square
            r_ps9   <= t_prod'(r_x8) * t_prod'(r_s8);
            r_pc9   <= mul_sq(r_sq8, r_c8);
            r_quad9 <= r_quad8;

            r_s10    <= n_s10;
            r_c10    <= shift_add(r_pc9, CosC0);
            r_quad10 <= r_quad9;

            r_sin11 <= n_sin11;
            r_cos11 <= n_cos11;
        end
    end

    a_stall_only_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result waiting");

    a_no_full_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sine_value != 16'sh8000) && (o_cosine_value != 16'sh8000))
        else $error("result escaped saturation");

    a_unit_circle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sine_value > 16'sd20000) || (o_sine_value < -16'sd20000) ||
                    (o_cosine_value > 16'sd20000) || (o_cosine_value < -16'sd20000))
        else $error("sine and cosine both small");

endmodule

`default_nettype wire
